// File: hw/rtl/rgtp_pkg.sv
// Shared types and constants for the color grid test pattern pixel block.
`timescale 1ns / 1ps

package rgtp_pkg;

	localparam int CHANNEL_BITS   = 8;
	localparam int RED_POSITION   = 16;
	localparam int GREEN_POSITION = 8;
	localparam int BLUE_POSITION  = 0;

	localparam logic [7:0] CHAN_MASK = 8'((1 << CHANNEL_BITS) - 1);

	localparam int CFG_DIV_STEPS = 11;
	localparam int DIV_BITS      = 8;

	typedef enum logic [2:0] {
		REG_RECT_COUNT   = 3'd0,
		REG_FIRST_COLOR  = 3'd1,
		REG_COLOR_STEP   = 3'd2,
		REG_INDEXED_MODE = 3'd3,
		REG_X_RES        = 3'd4,
		REG_Y_RES        = 3'd5,
		REG_BITS_PER_PIX = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CFG_IDLE,
		CFG_LOAD,
		CFG_DIVIDE,
		CFG_SCALE
	} cfg_state_t;

	typedef struct packed {
		logic [10:0] pixel_x;
		logic [10:0] pixel_y;
	} pixel_in_t;

	typedef struct packed {
		logic        drawn;
		logic [23:0] pixel_color;
		logic [23:0] byte_offset;
	} pixel_out_t;

	typedef struct packed {
		logic [7:0]  rect_count;
		logic [23:0] first_color;
		logic [7:0]  color_step;
		logic        indexed_mode;
		logic [10:0] x_res;
		logic [2:0]  bytes_pp;
		logic [23:0] color_mask;
		logic [10:0] rect_w;
		logic [10:0] rect_h;
		logic [10:0] grid_w;
		logic [10:0] grid_h;
		logic        grid_on;
	} cfg_t;

	typedef struct packed {
		logic [10:0] rem_x;
		logic [10:0] rem_y;
		logic [7:0]  quo_x;
		logic [7:0]  quo_y;
		logic        drawn;
		logic [23:0] acc;
	} grid_stage_t;

	typedef struct packed {
		logic [7:0]  row;
		logic [7:0]  col;
		logic        drawn;
		logic [23:0] byte_offset;
	} tile_t;

endpackage

// File: hw/rtl/rgtp_cfg.sv
// Configuration registers and derived rectangle geometry for the grid pattern.
`timescale 1ns / 1ps

module rgtp_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [23:0]   cfg_data,
	output rgtp_pkg::cfg_t cfg,
	output logic          busy
);
	import rgtp_pkg::*;

	logic [7:0]  rect_count_q;
	logic [23:0] first_color_q;
	logic [7:0]  color_step_q;
	logic        indexed_mode_q;
	logic [10:0] x_res_q;
	logic [10:0] y_res_q;
	logic [4:0]  bpp_q;

	cfg_state_t  state_q, state_d;
	logic [3:0]  cnt_q;
	logic [10:0] dvd_x_q, dvd_y_q;
	logic [8:0]  rem_x_q, rem_y_q;
	logic [10:0] grid_w_q, grid_h_q;
	logic        grid_on_q;

	logic        wr;
	logic [8:0]  sh_x, sh_y;
	logic        ge_x, ge_y;
	logic [5:0]  bpp_round;
	logic [18:0] gw_prod, gh_prod;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_count_q   <= 8'd1;
			first_color_q  <= 24'd0;
			color_step_q   <= 8'd1;
			indexed_mode_q <= 1'b1;
			x_res_q        <= 11'd1024;
			y_res_q        <= 11'd768;
			bpp_q          <= 5'd8;
		end else if (wr) begin
			case (cfg_index)
				REG_RECT_COUNT:   rect_count_q   <= cfg_data[7:0];
				REG_FIRST_COLOR:  first_color_q  <= cfg_data;
				REG_COLOR_STEP:   color_step_q   <= cfg_data[7:0];
				REG_INDEXED_MODE: indexed_mode_q <= cfg_data[0];
				REG_X_RES:        x_res_q        <= cfg_data[10:0];
				REG_Y_RES:        y_res_q        <= cfg_data[10:0];
				REG_BITS_PER_PIX: bpp_q          <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CFG_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CFG_IDLE:   state_d = CFG_IDLE;
			CFG_LOAD:   state_d = CFG_DIVIDE;
			CFG_DIVIDE: begin
				if (cnt_q == 4'(CFG_DIV_STEPS - 1)) state_d = CFG_SCALE;
			end
			CFG_SCALE:  state_d = CFG_IDLE;
			default:    state_d = CFG_LOAD;
		endcase
		if (wr) state_d = CFG_LOAD;
	end

	assign sh_x    = {rem_x_q[7:0], dvd_x_q[10]};
	assign sh_y    = {rem_y_q[7:0], dvd_y_q[10]};
	assign ge_x    = sh_x >= {1'b0, rect_count_q};
	assign ge_y    = sh_y >= {1'b0, rect_count_q};
	assign gw_prod = {8'd0, dvd_x_q} * {11'd0, rect_count_q};
	assign gh_prod = {8'd0, dvd_y_q} * {11'd0, rect_count_q};

	always_ff @(posedge clk) begin
		case (state_q)
			CFG_LOAD: begin
				dvd_x_q <= x_res_q;
				dvd_y_q <= y_res_q;
				rem_x_q <= 9'd0;
				rem_y_q <= 9'd0;
				cnt_q   <= 4'd0;
			end
			CFG_DIVIDE: begin
				rem_x_q <= ge_x ? sh_x - {1'b0, rect_count_q} : sh_x;
				rem_y_q <= ge_y ? sh_y - {1'b0, rect_count_q} : sh_y;
				dvd_x_q <= {dvd_x_q[9:0], ge_x};
				dvd_y_q <= {dvd_y_q[9:0], ge_y};
				cnt_q   <= cnt_q + 4'd1;
			end
			CFG_SCALE: begin
				grid_w_q  <= gw_prod[10:0];
				grid_h_q  <= gh_prod[10:0];
				grid_on_q <= (rect_count_q != 8'd0) && (dvd_x_q != 11'd0) &&
				             (dvd_y_q != 11'd0);
			end
			default: ;
		endcase
	end

	assign bpp_round = {1'b0, bpp_q} + 6'd7;

	always_comb begin
		cfg.rect_count   = rect_count_q;
		cfg.first_color  = first_color_q;
		cfg.color_step   = color_step_q;
		cfg.indexed_mode = indexed_mode_q;
		cfg.x_res        = x_res_q;
		cfg.bytes_pp     = bpp_round[5:3];
		cfg.color_mask   = (bpp_q >= 5'd24) ? 24'hFFFFFF : ((24'd1 << bpp_q) - 24'd1);
		cfg.rect_w       = dvd_x_q;
		cfg.rect_h       = dvd_y_q;
		cfg.grid_w       = grid_w_q;
		cfg.grid_h       = grid_h_q;
		cfg.grid_on      = grid_on_q;
	end

	assign busy = state_q != CFG_IDLE;

endmodule

// File: hw/rtl/rgtp_grid.sv
// Grid cell lookup: bit-per-stage column and row division, coverage and byte offset.
`timescale 1ns / 1ps

module rgtp_grid (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               beat,
	input  rgtp_pkg::pixel_in_t pixel,
	input  rgtp_pkg::cfg_t     cfg,
	output logic               tile_valid,
	output rgtp_pkg::tile_t    tile
);
	import rgtp_pkg::*;

	grid_stage_t grid_s [DIV_BITS+1];
	logic        grid_vld_s [DIV_BITS+1];
	logic [21:0] lin_prod;

	assign lin_prod = {11'd0, pixel.pixel_y} * {11'd0, cfg.x_res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_vld_s[0] <= 1'b0;
		end else if (en) begin
			grid_vld_s[0] <= beat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grid_s[0].rem_x <= pixel.pixel_x;
			grid_s[0].rem_y <= pixel.pixel_y;
			grid_s[0].quo_x <= 8'd0;
			grid_s[0].quo_y <= 8'd0;
			grid_s[0].drawn <= cfg.grid_on && (pixel.pixel_x < cfg.grid_w) &&
			                   (pixel.pixel_y < cfg.grid_h);
			grid_s[0].acc   <= {2'd0, lin_prod};
		end
	end

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		localparam int B = DIV_BITS - 1 - k;
		logic [18:0] dx, dy;
		logic        ge_x, ge_y;
		logic [23:0] acc_d;

		assign dx   = {8'd0, cfg.rect_w} << B;
		assign dy   = {8'd0, cfg.rect_h} << B;
		assign ge_x = {8'd0, grid_s[k].rem_x} >= dx;
		assign ge_y = {8'd0, grid_s[k].rem_y} >= dy;

		if (k == 0) begin : g_lin
			assign acc_d = grid_s[k].acc + {13'd0, grid_s[k].rem_x};
		end else if (k == 1) begin : g_scale
			logic [26:0] scaled;
			assign scaled = {3'd0, grid_s[k].acc} * {24'd0, cfg.bytes_pp};
			assign acc_d  = scaled[23:0];
		end else begin : g_hold
			assign acc_d = grid_s[k].acc;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				grid_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				grid_vld_s[k+1] <= grid_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				grid_s[k+1].rem_x <= ge_x ? grid_s[k].rem_x - dx[10:0] : grid_s[k].rem_x;
				grid_s[k+1].rem_y <= ge_y ? grid_s[k].rem_y - dy[10:0] : grid_s[k].rem_y;
				grid_s[k+1].quo_x <= grid_s[k].quo_x | (8'(ge_x) << B);
				grid_s[k+1].quo_y <= grid_s[k].quo_y | (8'(ge_y) << B);
				grid_s[k+1].drawn <= grid_s[k].drawn;
				grid_s[k+1].acc   <= acc_d;
			end
		end
	end

	assign tile_valid       = grid_vld_s[DIV_BITS];
	assign tile.row         = grid_s[DIV_BITS].quo_y;
	assign tile.col         = grid_s[DIV_BITS].quo_x;
	assign tile.drawn       = grid_s[DIV_BITS].drawn;
	assign tile.byte_offset = grid_s[DIV_BITS].acc;

endmodule

// File: hw/rtl/rgtp_color.sv
// Rectangle color stages for indexed and direct RGB modes, ending in the result register.
`timescale 1ns / 1ps

module rgtp_color (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 tile_valid,
	input  rgtp_pkg::tile_t      tile,
	input  rgtp_pkg::cfg_t       cfg,
	output logic                 result_valid,
	output rgtp_pkg::pixel_out_t result
);
	import rgtp_pkg::*;

	logic        vld_s1, vld_s2, vld_s3;
	logic [16:0] tile_idx_s1;
	logic [7:0]  r_inc_s1, g_inc_s1, b_inc_s1;
	logic        drawn_s1, drawn_s2;
	logic [23:0] offset_s1, offset_s2;
	logic [24:0] idx_prod_s2;
	logic [23:0] direct_s2;
	pixel_out_t  result_s3;

	logic [15:0] col_n;
	logic [15:0] r_mul, g_mul, b_mul;
	logic [8:0]  diag;
	logic [16:0] b_full;
	logic [7:0]  r_ch, g_ch, b_ch;
	logic [25:0] idx_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= tile_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign col_n  = {8'd0, tile.col} * {8'd0, cfg.rect_count};
	assign r_mul  = {8'd0, tile.row} * {8'd0, cfg.color_step};
	assign g_mul  = {8'd0, tile.col} * {8'd0, cfg.color_step};
	assign diag   = {1'b0, tile.row} + {1'b0, tile.col};
	assign b_full = {8'd0, diag} * {9'd0, cfg.color_step};
	assign b_mul  = b_full[15:0];

	always_ff @(posedge clk) begin
		if (en) begin
			tile_idx_s1 <= {1'b0, col_n} + {9'd0, tile.row};
			r_inc_s1    <= r_mul[7:0];
			g_inc_s1    <= g_mul[7:0];
			b_inc_s1    <= b_mul[7:0];
			drawn_s1    <= tile.drawn;
			offset_s1   <= tile.byte_offset;
		end
	end

	assign r_ch = (8'(cfg.first_color >> RED_POSITION) + r_inc_s1) & CHAN_MASK;
	assign g_ch = (8'(cfg.first_color >> GREEN_POSITION) + g_inc_s1) & CHAN_MASK;
	assign b_ch = (8'(cfg.first_color >> BLUE_POSITION) + b_inc_s1) & CHAN_MASK;

	always_ff @(posedge clk) begin
		if (en) begin
			idx_prod_s2 <= {8'd0, tile_idx_s1} * {17'd0, cfg.color_step};
			direct_s2   <= ({16'd0, r_ch} << RED_POSITION) |
			               ({16'd0, g_ch} << GREEN_POSITION) |
			               ({16'd0, b_ch} << BLUE_POSITION);
			drawn_s2    <= drawn_s1;
			offset_s2   <= offset_s1;
		end
	end

	assign idx_sum = {2'd0, cfg.first_color} + {1'b0, idx_prod_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			result_s3.drawn       <= drawn_s2;
			result_s3.byte_offset <= offset_s2;
			if (!drawn_s2) begin
				result_s3.pixel_color <= 24'd0;
			end else if (cfg.indexed_mode) begin
				result_s3.pixel_color <= idx_sum[23:0] & cfg.color_mask;
			end else begin
				result_s3.pixel_color <= direct_s2;
			end
		end
	end

	assign result_valid = vld_s3;
	assign result       = result_s3;

endmodule

// File: hw/rtl/rect_grid_test_pattern_pixel_top.sv
// An accepted pixel beat passes the input register, the divide stages and the color stages to its result beat.
// Throughput: one pixel per cycle; the 8 one-bit divide stages and the
// color stages all advance together and hold as a whole when the result is not taken.
// Reset and every register write start a rectangle size calculation
// (serial divide of x_res and y_res by rect_count), during which pixel_ready is low.
`timescale 1ns / 1ps

module rect_grid_test_pattern_pixel_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pixel_valid,
	output logic                 pixel_ready,
	input  rgtp_pkg::pixel_in_t  pixel,
	output logic                 result_valid,
	input  logic                 result_ready,
	output rgtp_pkg::pixel_out_t result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [23:0]          cfg_data
);
	import rgtp_pkg::*;

	cfg_t  cfg;
	logic  busy;
	logic  en;
	logic  beat;
	logic  tile_valid;
	tile_t tile;

	assign en          = !result_valid || result_ready;
	assign pixel_ready = en && !busy;
	assign beat        = pixel_valid && pixel_ready;

	rgtp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.busy      (busy)
	);

	rgtp_grid u_grid (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.beat       (beat),
		.pixel      (pixel),
		.cfg        (cfg),
		.tile_valid (tile_valid),
		.tile       (tile)
	);

	rgtp_color u_color (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.tile_valid   (tile_valid),
		.tile         (tile),
		.cfg          (cfg),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
